### rtl/pcrs_pkg.sv
package pcrs_pkg;

    localparam int DEF_MAX_BINS     = 1024;
    localparam int DEF_CORDIC_STEPS = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COORD_W    = 32;
    localparam int RANGE_W    = 32;
    localparam int ANGLE_W    = 19;
    localparam int COUNT_W    = 11;
    localparam int INDEX_W    = 10;
    localparam int STATUS_W   = 2;
    localparam int STEP_W     = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT  = 3'd5;

    localparam logic OP_ACCUMULATE = 1'b0;
    localparam logic OP_READ       = 1'b1;

    localparam logic [STATUS_W-1:0] ST_HIT    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BEYOND = 2'd2;

    localparam logic [RANGE_W-1:0] NO_RETURN = '1;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

    typedef struct packed {
        logic              in_rdy;
        logic              sq_x;
        logic              sq_y;
        logic              iter;
        logic              cordic_en;
        logic [STEP_W-1:0] step;
        logic              check;
        logic              div;
        logic              acc_rd;
        logic              acc_wr;
        logic              rd_rd;
        logic              rd_clr;
        logic              out_load;
        logic              out_miss;
        logic              clr_wr;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic op;
        logic idx_ok;
        logic pass;
        logic bin_ok;
        logic out_busy;
        logic clr_last;
    } t_status;

    function automatic logic [30:0] atan_q30(input logic [STEP_W-1:0] i);
        logic [30:0] v;
        unique case (i)
            5'd0:  v = 31'd843314857;
            5'd1:  v = 31'd497837829;
            5'd2:  v = 31'd263043837;
            5'd3:  v = 31'd133525159;
            5'd4:  v = 31'd67021687;
            5'd5:  v = 31'd33543516;
            5'd6:  v = 31'd16775851;
            5'd7:  v = 31'd8388437;
            5'd8:  v = 31'd4194283;
            5'd9:  v = 31'd2097149;
            5'd10: v = 31'd1048576;
            5'd11: v = 31'd524288;
            5'd12: v = 31'd262144;
            5'd13: v = 31'd131072;
            5'd14: v = 31'd65536;
            5'd15: v = 31'd32768;
            5'd16: v = 31'd16384;
            5'd17: v = 31'd8192;
            5'd18: v = 31'd4096;
            5'd19: v = 31'd2048;
            5'd20: v = 31'd1024;
            5'd21: v = 31'd512;
            5'd22: v = 31'd256;
            5'd23: v = 31'd128;
            5'd24: v = 31'd64;
            5'd25: v = 31'd32;
            5'd26: v = 31'd16;
            5'd27: v = 31'd8;
            5'd28: v = 31'd4;
            5'd29: v = 31'd2;
            5'd30: v = 31'd1;
            5'd31: v = 31'd1;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/pcrs_in_if.sv
interface pcrs_in_if
    import pcrs_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic [INDEX_W-1:0]         bin_index;

    modport source (output valid, opcode, point_x, point_y, bin_index, input ready);
    modport sink (input valid, opcode, point_x, point_y, bin_index, output ready);
endinterface

### rtl/pcrs_out_if.sv
interface pcrs_out_if
    import pcrs_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [RANGE_W-1:0]    bin_range;

    modport source (output valid, status, bin_range, input ready);
    modport sink (input valid, status, bin_range, output ready);
endinterface

### rtl/pcrs_cfg_if.sv
interface pcrs_cfg_if
    import pcrs_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_W-1:0]    index;
    logic [CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/pcrs_datapath.sv
module pcrs_datapath
    import pcrs_pkg::*;
#(
    parameter int MAX_BINS = DEF_MAX_BINS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pcrs_in_if.sink       i_in,
    pcrs_cfg_if.sink      i_cfg,
    pcrs_out_if.source    o_out,
    input  t_cmd          i_cmd,
    output t_status       o_status
);
    localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CW = 36;
    localparam int CMPW = 21;
    localparam logic [CMPW-1:0] MAXB = CMPW'(MAX_BINS);

    logic signed [ANGLE_W-1:0] r_angle_low, r_angle_high;
    logic [ANGLE_W-1:0]        r_angle_step;
    logic [RANGE_W-1:0]        r_range_low, r_range_high;
    logic [COUNT_W-1:0]        r_bin_count;

    logic                      r_op;
    logic signed [COORD_W-1:0] r_x, r_y;
    logic [INDEX_W-1:0]        r_idx;
    logic                      r_zero;

    logic [63:0]               r_sum, r_rad;
    logic [34:0]               r_rem;
    logic [31:0]               r_root;

    logic signed [CW-1:0]      r_cx, r_cy;
    logic signed [33:0]        r_cz;

    logic [19:0]               r_q;
    logic [19:0]               r_dr;

    logic [RANGE_W-1:0]        mem [MAX_BINS];
    logic [RANGE_W-1:0]        r_rdata;
    logic [AW-1:0]             r_clr_addr;

    logic                      r_ov;
    logic [STATUS_W-1:0]       r_ostatus;
    logic [RANGE_W-1:0]        r_orange;

    logic [31:0]               ax, ay, m_op;
    logic [63:0]               prod;
    logic [34:0]               rem_t, trial;
    logic signed [CW-1:0]      xe, ye, xs, ys;
    logic signed [33:0]        z_rnd;
    logic signed [19:0]        ang;
    logic signed [20:0]        ang_w, alow_w, ahigh_w, num;
    logic [19:0]               dv_t, step_w;
    logic [CMPW-1:0]           cnt_w, n_use;
    logic [AW+19:0]            bin_ext;
    logic [AW+INDEX_W-1:0]     idx_ext;
    logic [AW-1:0]             bin_addr, idx_addr, ra, wa;
    logic                      re, we;
    logic [RANGE_W-1:0]        wd;
    logic                      accept;

    assign accept = i_in.valid && i_cmd.in_rdy;
    assign i_in.ready = i_cmd.in_rdy;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_low  <= -19'sd205783;
            r_angle_high <= 19'sd205783;
            r_angle_step <= 19'd655;
            r_range_low  <= 32'd0;
            r_range_high <= 32'd655360;
            r_bin_count  <= 11'd628;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_ANGLE_LOW:  r_angle_low  <= i_cfg.data[ANGLE_W-1:0];
                CFG_ANGLE_HIGH: r_angle_high <= i_cfg.data[ANGLE_W-1:0];
                CFG_ANGLE_STEP: r_angle_step <= i_cfg.data[ANGLE_W-1:0];
                CFG_RANGE_LOW:  r_range_low  <= i_cfg.data[RANGE_W-1:0];
                CFG_RANGE_HIGH: r_range_high <= i_cfg.data[RANGE_W-1:0];
                CFG_BIN_COUNT:  r_bin_count  <= i_cfg.data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // squares through one shared multiplier
    assign ax = r_x[COORD_W-1] ? 32'(-r_x) : 32'(r_x);
    assign ay = r_y[COORD_W-1] ? 32'(-r_y) : 32'(r_y);
    assign m_op = i_cmd.sq_x ? ax : ay;
    assign prod = 64'(m_op) * 64'(m_op);

    assign rem_t = {r_rem[32:0], r_rad[63:62]};
    assign trial = {1'b0, r_root, 2'b01};

    assign xe = CW'(r_x);
    assign ye = CW'(r_y);
    assign xs = r_cx >>> i_cmd.step;
    assign ys = r_cy >>> i_cmd.step;

    assign z_rnd = (r_cz + 34'sd8192) >>> 14;
    assign ang = r_zero ? 20'sd0 : z_rnd[19:0];
    assign ang_w = 21'(ang);
    assign alow_w = 21'(r_angle_low);
    assign ahigh_w = 21'(r_angle_high);
    assign num = ang_w - alow_w;

    assign step_w = 20'(r_angle_step);
    assign dv_t = {r_dr[18:0], r_q[19]};

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_in.opcode;
            r_x   <= i_in.point_x;
            r_y   <= i_in.point_y;
            r_idx <= i_in.bin_index;
        end
        if (i_cmd.sq_x) begin
            r_sum  <= prod;
            r_zero <= (r_x == '0) && (r_y == '0);
        end
        if (i_cmd.sq_y) begin
            r_rad  <= r_sum + prod;
            r_rem  <= '0;
            r_root <= '0;
            if (r_x[COORD_W-1]) begin
                if (!r_y[COORD_W-1]) begin
                    r_cx <= ye;
                    r_cy <= -xe;
                    r_cz <= HALF_PI_Q30;
                end else begin
                    r_cx <= -ye;
                    r_cy <= xe;
                    r_cz <= -HALF_PI_Q30;
                end
            end else begin
                r_cx <= xe;
                r_cy <= ye;
                r_cz <= '0;
            end
        end
        if (i_cmd.iter) begin
            r_rad <= {r_rad[61:0], 2'b00};
            if (rem_t >= trial) begin
                r_rem  <= rem_t - trial;
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= rem_t;
                r_root <= {r_root[30:0], 1'b0};
            end
            if (i_cmd.cordic_en) begin
                if (!r_cy[CW-1]) begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + 34'(atan_q30(i_cmd.step));
                end else begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - 34'(atan_q30(i_cmd.step));
                end
            end
        end
        if (i_cmd.check) begin
            r_q  <= num[19:0];
            r_dr <= '0;
        end
        if (i_cmd.div) begin
            if (dv_t >= step_w) begin
                r_dr <= dv_t - step_w;
                r_q  <= {r_q[18:0], 1'b1};
            end else begin
                r_dr <= dv_t;
                r_q  <= {r_q[18:0], 1'b0};
            end
        end
    end

    assign cnt_w = CMPW'(r_bin_count);
    assign n_use = (cnt_w < MAXB) ? cnt_w : MAXB;

    assign bin_ext  = {{AW{1'b0}}, r_q};
    assign idx_ext  = {{AW{1'b0}}, r_idx};
    assign bin_addr = bin_ext[AW-1:0];
    assign idx_addr = idx_ext[AW-1:0];

    // bin store
    assign re = i_cmd.acc_rd || i_cmd.rd_rd;
    assign ra = i_cmd.acc_rd ? bin_addr : idx_addr;
    assign we = i_cmd.clr_wr || i_cmd.rd_clr || (i_cmd.acc_wr && (r_root < r_rdata));
    assign wa = i_cmd.clr_wr ? r_clr_addr : (i_cmd.rd_clr ? idx_addr : bin_addr);
    assign wd = i_cmd.acc_wr ? r_root : NO_RETURN;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            r_rdata <= mem[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
        if (i_cmd.out_load) begin
            if (i_cmd.out_miss) begin
                r_ostatus <= ST_BEYOND;
                r_orange  <= NO_RETURN;
            end else begin
                r_ostatus <= (r_rdata == NO_RETURN) ? ST_EMPTY : ST_HIT;
                r_orange  <= r_rdata;
            end
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.status    = r_ostatus;
    assign o_out.bin_range = r_orange;

    assign o_status.in_valid = i_in.valid;
    assign o_status.op       = r_op;
    assign o_status.idx_ok   = CMPW'(r_idx) < n_use;
    assign o_status.pass     = (r_root >= r_range_low) && (r_root <= r_range_high)
                               && (ang_w >= alow_w) && (ang_w <= ahigh_w)
                               && (r_angle_step != '0);
    assign o_status.bin_ok   = CMPW'(r_q) < n_use;
    assign o_status.out_busy = r_ov && !o_out.ready;
    assign o_status.clr_last = (r_clr_addr == AW'(MAX_BINS - 1));
endmodule

### rtl/pcrs_ctrl.sv
module pcrs_ctrl
    import pcrs_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    localparam int STEPS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    localparam logic [STEP_W-1:0] LAST_ROOT = STEP_W'(31);
    localparam logic [STEP_W-1:0] LAST_DIV  = STEP_W'(19);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DEC, S_SQY, S_ITER, S_CHECK,
        S_DIV, S_BIN, S_ACC_WR, S_RD_OUT, S_MISS
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: if (i_status.clr_last) r_state <= S_IDLE;
                S_IDLE:  if (i_status.in_valid) r_state <= S_DEC;
                S_DEC: begin
                    if (i_status.op == OP_ACCUMULATE) begin
                        r_state <= S_SQY;
                    end else if (i_status.idx_ok) begin
                        r_state <= S_RD_OUT;
                    end else begin
                        r_state <= S_MISS;
                    end
                end
                S_SQY: begin
                    r_state <= S_ITER;
                    r_cnt   <= '0;
                end
                S_ITER: begin
                    r_cnt <= r_cnt + STEP_W'(1);
                    if (r_cnt == LAST_ROOT) r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_cnt   <= '0;
                    r_state <= i_status.pass ? S_DIV : S_IDLE;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + STEP_W'(1);
                    if (r_cnt == LAST_DIV) r_state <= S_BIN;
                end
                S_BIN:    r_state <= i_status.bin_ok ? S_ACC_WR : S_IDLE;
                S_ACC_WR: r_state <= S_IDLE;
                S_RD_OUT: if (!i_status.out_busy) r_state <= S_IDLE;
                S_MISS:   if (!i_status.out_busy) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.step      = r_cnt;
        o_cmd.in_rdy    = (r_state == S_IDLE);
        o_cmd.clr_wr    = (r_state == S_CLEAR);
        o_cmd.sq_x      = (r_state == S_DEC) && (i_status.op == OP_ACCUMULATE);
        o_cmd.rd_rd     = (r_state == S_DEC) && (i_status.op == OP_READ) && i_status.idx_ok;
        o_cmd.sq_y      = (r_state == S_SQY);
        o_cmd.iter      = (r_state == S_ITER);
        o_cmd.cordic_en = (r_state == S_ITER) && (32'(r_cnt) < STEPS);
        o_cmd.check     = (r_state == S_CHECK);
        o_cmd.div       = (r_state == S_DIV);
        o_cmd.acc_rd    = (r_state == S_BIN) && i_status.bin_ok;
        o_cmd.acc_wr    = (r_state == S_ACC_WR);
        o_cmd.out_load  = ((r_state == S_RD_OUT) || (r_state == S_MISS)) && !i_status.out_busy;
        o_cmd.rd_clr    = (r_state == S_RD_OUT) && !i_status.out_busy;
        o_cmd.out_miss  = (r_state == S_MISS);
    end
endmodule

### rtl/point_cloud_to_range_scan_unit.sv
// accumulate: a 32-step square root (with the cordic alongside), then a 20-step bin divide
// and the bin update; a point outside the windows stops after the window check, and one
// whose bin is beyond the count in use stops before the update; no result is produced
// read and clear: the entry is read on decode, then registered as the result and cleared
// once the result register is free; the next item is taken only after that
// after reset the bin store is cleared one entry a cycle, all MAX_BINS entries,
// before the first item is accepted; configuration writes are taken throughout
module point_cloud_to_range_scan_unit
    import pcrs_pkg::*;
#(
    parameter int MAX_BINS     = DEF_MAX_BINS,
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcrs_in_if.sink    i_in,
    pcrs_cfg_if.sink   i_cfg,
    pcrs_out_if.source o_out
);
    t_cmd    cmd;
    t_status status;

    pcrs_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    pcrs_datapath #(
        .MAX_BINS(MAX_BINS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .o_out    (o_out),
        .i_cmd    (cmd),
        .o_status (status)
    );
endmodule
